// ===== rtl/elg_pkg.sv =====
`timescale 1ns / 1ps

package elg_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);
    localparam int IDX_BITS  = 2;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_BITS-1:0]  t_cnt;
    typedef logic [IDX_BITS-1:0]  t_idx;

    localparam t_idx REG_MODULUS     = 2'd0;
    localparam t_idx REG_GENERATOR   = 2'd1;
    localparam t_idx REG_PRIVATE_KEY = 2'd2;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam t_cnt LAST_BIT = t_cnt'(WORD_BITS - 1);
    localparam t_cnt ALL_BITS = t_cnt'(WORD_BITS);

    typedef enum logic [4:0] {
        S_IDLE,
        S_G_RED,
        S_PUB_DONE,
        S_C1_DONE,
        S_Y_DONE,
        S_M_RED,
        S_C2_MUL,
        S_C1_RED,
        S_EU_TEST,
        S_EU_DIV,
        S_EU_MUL,
        S_C2_RED,
        S_INV_DONE,
        S_PL_MUL,
        S_POW_MUL,
        S_POW_MW,
        S_POW_SQ,
        S_POW_SW,
        S_FINISH
    } t_state;

    // Sum of two residues below p, brought back below p.
    function automatic t_word add_mod(input t_word a, input t_word b, input t_word p);
        logic [WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[WORD_BITS-1:0];
    endfunction

endpackage

// ===== rtl/elg_mulmod.sv =====
`timescale 1ns / 1ps

module elg_mulmod (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  elg_pkg::t_word i_a,
    input  elg_pkg::t_word i_b,
    input  elg_pkg::t_word i_p,
    output logic           o_done,
    output elg_pkg::t_word o_result
);

    logic           r_busy;
    elg_pkg::t_word r_acc;
    elg_pkg::t_word r_aa;
    elg_pkg::t_word r_bb;
    elg_pkg::t_word r_p;

    assign o_done   = r_busy && (r_bb == '0);
    assign o_result = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // One multiplier bit per cycle: add the doubled operand where the bit is set.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_aa  <= i_a;
            r_bb  <= i_b;
            r_p   <= i_p;
        end else if (r_busy && (r_bb != '0)) begin
            if (r_bb[0]) begin
                r_acc <= elg_pkg::add_mod(r_acc, r_aa, r_p);
            end
            r_aa <= elg_pkg::add_mod(r_aa, r_aa, r_p);
            r_bb <= r_bb >> 1;
        end
    end

endmodule

// ===== rtl/elg_divu.sv =====
`timescale 1ns / 1ps

module elg_divu (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  elg_pkg::t_word i_num,
    input  elg_pkg::t_word i_den,
    output logic           o_done,
    output elg_pkg::t_word o_quo,
    output elg_pkg::t_word o_rem
);

    logic                         r_busy;
    elg_pkg::t_cnt                r_cnt;
    elg_pkg::t_word               r_rem;
    elg_pkg::t_word               r_quo;
    elg_pkg::t_word               r_den;
    logic [elg_pkg::WORD_BITS:0]  trial;
    logic                         fits;

    assign trial  = {r_rem, r_quo[elg_pkg::WORD_BITS-1]};
    assign fits   = trial >= {1'b0, r_den};
    assign o_done = r_busy && (r_cnt == elg_pkg::ALL_BITS);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Restoring division: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy && !o_done) begin
            if (fits) begin
                r_rem <= elg_pkg::WORD_BITS'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[elg_pkg::WORD_BITS-1:0];
            end
            r_quo <= {r_quo[elg_pkg::WORD_BITS-2:0], fits};
        end
    end

endmodule

// ===== rtl/elgamal_encrypt_decrypt.sv =====
`timescale 1ns / 1ps

// ElGamal encrypt and decrypt over a configured modulus, generator and private key.
// Configuration: write index 0 (modulus), 1 (generator) or 2 (private key) with data on
// the cfg channel, which is always ready; other indexes are ignored. Write only when idle.
// Input channel: cmd 0 encrypts message with nonce, cmd 1 decrypts given_first/second.
// Output channel: one item per input item, with the public key and the cipher parts,
// plaintext and no_inverse flag, unused fields zero.
// Arithmetic: all products run on one add-and-double modular multiplier and all
// reductions and divisions on one restoring divider. Each modular power costs up to
// 64 products. Encrypt takes three powers; decrypt takes one power, the extended Euclid
// loop (up to about 47 rounds of one division and one product) and one power.
// A zero modulus skips all arithmetic. One item is processed at a time.
// The input is ready again once a result is registered; if the receiver stalls, the next
// item is computed and then held until the previous result is taken.
// Reset restores modulus 3, generator 2, private key 1 and drops any pending result.

module elgamal_encrypt_decrypt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  elg_pkg::t_idx  i_cfg_index,
    input  elg_pkg::t_word i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_cmd,
    input  elg_pkg::t_word i_message,
    input  elg_pkg::t_word i_nonce,
    input  elg_pkg::t_word i_given_first,
    input  elg_pkg::t_word i_given_second,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output elg_pkg::t_word o_public_key,
    output elg_pkg::t_word o_cipher_first,
    output elg_pkg::t_word o_cipher_second,
    output elg_pkg::t_word o_plaintext,
    output logic           o_no_inverse
);

    elg_pkg::t_state r_state, n_state;
    elg_pkg::t_state r_ret, n_ret;
    logic            r_out_valid, n_out_valid;

    elg_pkg::t_word r_p, r_g, r_x;

    logic           r_cmd, n_cmd;
    elg_pkg::t_word r_msg, n_msg, r_nonce, n_nonce, r_c1in, n_c1in, r_c2in, n_c2in;
    elg_pkg::t_word r_gr, n_gr, r_pub, n_pub, r_c1, n_c1, r_c2, n_c2;
    elg_pkg::t_word r_plain, n_plain, r_m, n_m;
    logic           r_err, n_err;
    elg_pkg::t_word r_r0, n_r0, r_r1, n_r1, r_r2, n_r2, r_t0, n_t0, r_t1, n_t1;
    elg_pkg::t_word r_acc, n_acc, r_base, n_base, r_exp, n_exp;
    elg_pkg::t_cnt  r_cnt, n_cnt;

    elg_pkg::t_word r_o_pub, n_o_pub, r_o_c1, n_o_c1, r_o_c2, n_o_c2;
    elg_pkg::t_word r_o_plain, n_o_plain;
    logic           r_o_err, n_o_err;

    logic           mul_start, mul_done;
    elg_pkg::t_word mul_a, mul_b, mul_res;
    logic           div_start, div_done;
    elg_pkg::t_word div_num, div_den, div_quo, div_rem;

    elg_pkg::t_word one_mod_p;
    elg_pkg::t_word q_mod;

    assign one_mod_p = (r_p == elg_pkg::t_word'(1)) ? '0 : elg_pkg::t_word'(1);
    // The quotient never exceeds p, so one subtraction reduces it.
    assign q_mod     = (div_quo >= r_p) ? div_quo - r_p : div_quo;

    elg_mulmod u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .i_p      (r_p),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    elg_divu u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_in_ready      = (r_state == elg_pkg::S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_public_key    = r_o_pub;
    assign o_cipher_first  = r_o_c1;
    assign o_cipher_second = r_o_c2;
    assign o_plaintext     = r_o_plain;
    assign o_no_inverse    = r_o_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= elg_pkg::S_IDLE;
            r_ret       <= elg_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_p         <= elg_pkg::t_word'(3);
            r_g         <= elg_pkg::t_word'(2);
            r_x         <= elg_pkg::t_word'(1);
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    elg_pkg::REG_MODULUS:     r_p <= i_cfg_data;
                    elg_pkg::REG_GENERATOR:   r_g <= i_cfg_data;
                    elg_pkg::REG_PRIVATE_KEY: r_x <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_msg     <= n_msg;
        r_nonce   <= n_nonce;
        r_c1in    <= n_c1in;
        r_c2in    <= n_c2in;
        r_gr      <= n_gr;
        r_pub     <= n_pub;
        r_c1      <= n_c1;
        r_c2      <= n_c2;
        r_plain   <= n_plain;
        r_m       <= n_m;
        r_err     <= n_err;
        r_r0      <= n_r0;
        r_r1      <= n_r1;
        r_r2      <= n_r2;
        r_t0      <= n_t0;
        r_t1      <= n_t1;
        r_acc     <= n_acc;
        r_base    <= n_base;
        r_exp     <= n_exp;
        r_o_pub   <= n_o_pub;
        r_o_c1    <= n_o_c1;
        r_o_c2    <= n_o_c2;
        r_o_plain <= n_o_plain;
        r_o_err   <= n_o_err;
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_msg       = r_msg;
        n_nonce     = r_nonce;
        n_c1in      = r_c1in;
        n_c2in      = r_c2in;
        n_gr        = r_gr;
        n_pub       = r_pub;
        n_c1        = r_c1;
        n_c2        = r_c2;
        n_plain     = r_plain;
        n_m         = r_m;
        n_err       = r_err;
        n_r0        = r_r0;
        n_r1        = r_r1;
        n_r2        = r_r2;
        n_t0        = r_t0;
        n_t1        = r_t1;
        n_acc       = r_acc;
        n_base      = r_base;
        n_exp       = r_exp;
        n_cnt       = r_cnt;
        n_o_pub     = r_o_pub;
        n_o_c1      = r_o_c1;
        n_o_c2      = r_o_c2;
        n_o_plain   = r_o_plain;
        n_o_err     = r_o_err;
        mul_start   = 1'b0;
        mul_a       = r_acc;
        mul_b       = r_base;
        div_start   = 1'b0;
        div_num     = r_g;
        div_den     = r_p;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            elg_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_msg   = i_message;
                    n_nonce = i_nonce;
                    n_c1in  = i_given_first;
                    n_c2in  = i_given_second;
                    n_pub   = '0;
                    n_c1    = '0;
                    n_c2    = '0;
                    n_plain = '0;
                    n_err   = 1'b0;
                    if (r_p == '0) begin
                        n_err   = i_cmd;
                        n_state = elg_pkg::S_FINISH;
                    end else begin
                        div_start = 1'b1;
                        div_num   = r_g;
                        n_state   = elg_pkg::S_G_RED;
                    end
                end
            end
            elg_pkg::S_G_RED: begin
                if (div_done) begin
                    n_gr    = div_rem;
                    n_acc   = one_mod_p;
                    n_base  = div_rem;
                    n_exp   = r_x;
                    n_cnt   = '0;
                    n_ret   = elg_pkg::S_PUB_DONE;
                    n_state = elg_pkg::S_POW_MUL;
                end
            end
            elg_pkg::S_PUB_DONE: begin
                n_pub = r_acc;
                if (r_cmd == elg_pkg::CMD_ENCRYPT) begin
                    n_acc   = one_mod_p;
                    n_base  = r_gr;
                    n_exp   = r_nonce;
                    n_cnt   = '0;
                    n_ret   = elg_pkg::S_C1_DONE;
                    n_state = elg_pkg::S_POW_MUL;
                end else begin
                    div_start = 1'b1;
                    div_num   = r_c1in;
                    n_state   = elg_pkg::S_C1_RED;
                end
            end
            elg_pkg::S_C1_DONE: begin
                n_c1    = r_acc;
                n_acc   = one_mod_p;
                n_base  = r_pub;
                n_exp   = r_nonce;
                n_cnt   = '0;
                n_ret   = elg_pkg::S_Y_DONE;
                n_state = elg_pkg::S_POW_MUL;
            end
            elg_pkg::S_Y_DONE: begin
                div_start = 1'b1;
                div_num   = r_msg;
                n_state   = elg_pkg::S_M_RED;
            end
            elg_pkg::S_M_RED: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_a     = div_rem;
                    mul_b     = r_acc;
                    n_state   = elg_pkg::S_C2_MUL;
                end
            end
            elg_pkg::S_C2_MUL: begin
                if (mul_done) begin
                    n_c2    = mul_res;
                    n_state = elg_pkg::S_FINISH;
                end
            end
            elg_pkg::S_C1_RED: begin
                if (div_done) begin
                    n_r0    = r_p;
                    n_r1    = div_rem;
                    n_t0    = '0;
                    n_t1    = one_mod_p;
                    n_state = elg_pkg::S_EU_TEST;
                end
            end
            elg_pkg::S_EU_TEST: begin
                if (r_r1 == '0) begin
                    if (r_r0 != elg_pkg::t_word'(1)) begin
                        n_err   = 1'b1;
                        n_state = elg_pkg::S_FINISH;
                    end else begin
                        div_start = 1'b1;
                        div_num   = r_c2in;
                        n_state   = elg_pkg::S_C2_RED;
                    end
                end else begin
                    div_start = 1'b1;
                    div_num   = r_r0;
                    div_den   = r_r1;
                    n_state   = elg_pkg::S_EU_DIV;
                end
            end
            elg_pkg::S_EU_DIV: begin
                if (div_done) begin
                    n_r2      = div_rem;
                    mul_start = 1'b1;
                    mul_a     = q_mod;
                    mul_b     = r_t1;
                    n_state   = elg_pkg::S_EU_MUL;
                end
            end
            elg_pkg::S_EU_MUL: begin
                if (mul_done) begin
                    // Modular subtraction; the word arithmetic wraps to the right residue.
                    if (r_t0 >= mul_res) begin
                        n_t1 = r_t0 - mul_res;
                    end else begin
                        n_t1 = r_t0 + r_p - mul_res;
                    end
                    n_t0    = r_t1;
                    n_r0    = r_r1;
                    n_r1    = r_r2;
                    n_state = elg_pkg::S_EU_TEST;
                end
            end
            elg_pkg::S_C2_RED: begin
                if (div_done) begin
                    n_m     = div_rem;
                    n_acc   = one_mod_p;
                    n_base  = r_t0;
                    n_exp   = r_x;
                    n_cnt   = '0;
                    n_ret   = elg_pkg::S_INV_DONE;
                    n_state = elg_pkg::S_POW_MUL;
                end
            end
            elg_pkg::S_INV_DONE: begin
                mul_start = 1'b1;
                mul_a     = r_m;
                mul_b     = r_acc;
                n_state   = elg_pkg::S_PL_MUL;
            end
            elg_pkg::S_PL_MUL: begin
                if (mul_done) begin
                    n_plain = mul_res;
                    n_state = elg_pkg::S_FINISH;
                end
            end
            elg_pkg::S_POW_MUL: begin
                if (r_exp[0]) begin
                    mul_start = 1'b1;
                    mul_a     = r_acc;
                    mul_b     = r_base;
                    n_state   = elg_pkg::S_POW_MW;
                end else begin
                    n_state = elg_pkg::S_POW_SQ;
                end
            end
            elg_pkg::S_POW_MW: begin
                if (mul_done) begin
                    n_acc   = mul_res;
                    n_state = elg_pkg::S_POW_SQ;
                end
            end
            elg_pkg::S_POW_SQ: begin
                mul_start = 1'b1;
                mul_a     = r_base;
                mul_b     = r_base;
                n_state   = elg_pkg::S_POW_SW;
            end
            elg_pkg::S_POW_SW: begin
                if (mul_done) begin
                    n_base = mul_res;
                    n_exp  = r_exp >> 1;
                    n_cnt  = r_cnt + 1'b1;
                    if (r_cnt == elg_pkg::LAST_BIT) begin
                        n_state = r_ret;
                    end else begin
                        n_state = elg_pkg::S_POW_MUL;
                    end
                end
            end
            elg_pkg::S_FINISH: begin
                // Hold the finished item until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_o_pub     = r_pub;
                    n_o_c1      = r_c1;
                    n_o_c2      = r_c2;
                    n_o_plain   = r_plain;
                    n_o_err     = r_err;
                    n_out_valid = 1'b1;
                    n_state     = elg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = elg_pkg::S_IDLE;
            end
        endcase
    end

endmodule
